/* rtl/clist_pkg.sv */
// Shared types and constants for the circular list block.
// Operation and status codes, controller states, field widths.
// No dependencies.
`timescale 1ns / 1ps

package clist_pkg;

   // Fixed field widths of the request and response words
   localparam int KIND_WIDTH   = 2;
   localparam int VALUE_WIDTH  = 32;
   localparam int IDX_WIDTH    = 16;
   localparam int LEN_WIDTH    = 7;
   localparam int STATUS_WIDTH = 2;

   // Remainder unit: two quotient bits resolved per cycle
   localparam int DIV_BITS   = 2;
   localparam int DIV_STEPS  = IDX_WIDTH / DIV_BITS;
   localparam int STEP_WIDTH = $clog2(DIV_STEPS);

   // Operation codes
   localparam logic [KIND_WIDTH-1:0] KIND_INSERT = 2'd0;
   localparam logic [KIND_WIDTH-1:0] KIND_READ   = 2'd1;
   localparam logic [KIND_WIDTH-1:0] KIND_REMOVE = 2'd2;

   // Status codes
   localparam logic [STATUS_WIDTH-1:0] STATUS_OK    = 2'd0;
   localparam logic [STATUS_WIDTH-1:0] STATUS_EMPTY = 2'd1;
   localparam logic [STATUS_WIDTH-1:0] STATUS_FULL  = 2'd2;

   // Controller states
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DIV,
      ST_RDWAIT,
      ST_SHIFT,
      ST_RESP
   } state_type;

endpackage

/* rtl/clist_mod.sv */
// Iterative remainder unit: index modulo current list length.
// Restoring division, DIV_BITS bits per cycle. Uses clist_pkg.
`timescale 1ns / 1ps

module clist_mod #(
   parameter int CW = 7
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  logic [clist_pkg::IDX_WIDTH-1:0] dividend,
   input  logic [CW-1:0]                 divisor,
   output logic                          done,
   output logic [CW-1:0]                 rem
);

   logic                                busy_ff, busy_in;
   logic                                done_ff, done_in;
   logic [clist_pkg::STEP_WIDTH-1:0]    step_ff, step_in;
   logic [clist_pkg::IDX_WIDTH-1:0]     dvd_ff, dvd_in;
   logic [CW-1:0]                       div_ff, div_in;
   logic [CW-1:0]                       rem_ff, rem_in;

   // Remainder step: shift in DIV_BITS dividend bits, subtract where it fits
   always_comb begin
      logic [CW:0]   trial;
      logic [CW-1:0] r;
      r     = rem_ff;
      trial = '0;
      for (int k = 0; k < clist_pkg::DIV_BITS; k++) begin
         trial = {r, dvd_ff[clist_pkg::IDX_WIDTH-1-k]};
         if (trial >= {1'b0, div_ff}) begin
            trial = trial - {1'b0, div_ff};
         end
         r = trial[CW-1:0];
      end
      rem_in = r;
   end

   // Sequencing
   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      step_in = step_ff;
      dvd_in  = dvd_ff;
      div_in  = div_ff;
      if (start) begin
         busy_in = 1'b1;
         step_in = '0;
         dvd_in  = dividend;
         div_in  = divisor;
      end else if (busy_ff) begin
         step_in = step_ff + clist_pkg::STEP_WIDTH'(1);
         dvd_in  = dvd_ff << clist_pkg::DIV_BITS;
         if (step_ff == clist_pkg::STEP_WIDTH'(clist_pkg::DIV_STEPS - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         step_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         step_ff <= step_in;
      end
      dvd_ff <= dvd_in;
      div_ff <= div_in;
      if (start) begin
         rem_ff <= '0;
      end else if (busy_ff) begin
         rem_ff <= rem_in;
      end
   end

   assign done = done_ff;
   assign rem  = rem_ff;

   // Checks
   a_rem_below_div: assert property (@(posedge clock) disable iff (reset)
      done_ff |-> (rem_ff < div_ff))
      else $error("remainder not below divisor");

   a_no_restart: assert property (@(posedge clock) disable iff (reset)
      start |-> !busy_ff)
      else $error("remainder unit restarted while busy");

   a_done_pulse: assert property (@(posedge clock) disable iff (reset)
      done_ff |=> !done_ff)
      else $error("done held for more than one cycle");

endmodule

/* rtl/clist_mem.sv */
// Entry store: one write port, one read port, registered read data.
// No dependencies.
`timescale 1ns / 1ps

module clist_mem #(
   parameter int DEPTH = 64,
   parameter int WIDTH = 32,
   parameter int AW    = 6
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] store [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         store[wr_addr] <= wr_data;
      end
   end

   // Read port
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= store[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* rtl/circular_list_insert_read_remove.sv */
// Bounded circular list: insert at front, read and remove at index mod length.
// Insert, spare and flagged words go from accept straight to the response state; read
// runs 8 remainder steps, then the memory read; remove runs the remainder steps, then
// moves the entries after the position one place forward, one entry moved a cycle.
// One word in flight: a new word is taken once the response state passes its result to
// the output registers; a held result keeps the next word in that state and stalls the input.
// Reset clears length, head and handshake state; entries are undefined until written
// and are only read below the current length. Depends on clist_pkg, clist_mod, clist_mem.
`timescale 1ns / 1ps

module circular_list_insert_read_remove #(
   parameter int CAPACITY   = 64,
   parameter int DATA_WIDTH = 32
) (
   input  logic                                     clock,
   input  logic                                     reset,
   input  logic                                     req_valid,
   output logic                                     req_ready,
   input  logic [clist_pkg::KIND_WIDTH-1:0]         req_kind,
   input  logic signed [clist_pkg::VALUE_WIDTH-1:0] req_value,
   input  logic [clist_pkg::IDX_WIDTH-1:0]          req_index,
   output logic                                     rsp_valid,
   input  logic                                     rsp_ready,
   output logic signed [clist_pkg::VALUE_WIDTH-1:0] rsp_read_value,
   output logic [clist_pkg::LEN_WIDTH-1:0]          rsp_length,
   output logic [clist_pkg::STATUS_WIDTH-1:0]       rsp_status
);

   localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam int CW = $clog2(CAPACITY + 1);

   clist_pkg::state_type state_ff, state_in;

   logic [AW-1:0]                         head_ff, head_in;
   logic [CW-1:0]                         count_ff, count_in;
   logic [AW-1:0]                         cur_ff, cur_in;
   logic [clist_pkg::KIND_WIDTH-1:0]      kind_ff, kind_in;
   logic [clist_pkg::VALUE_WIDTH-1:0]     res_value_ff, res_value_in;
   logic [clist_pkg::STATUS_WIDTH-1:0]    res_status_ff, res_status_in;

   logic                                  rsp_valid_ff, rsp_valid_in;
   logic [clist_pkg::VALUE_WIDTH-1:0]     rsp_value_ff;
   logic [clist_pkg::LEN_WIDTH-1:0]       rsp_length_ff;
   logic [clist_pkg::STATUS_WIDTH-1:0]    rsp_status_ff;

   logic                                  mem_wr_en, mem_rd_en;
   logic [AW-1:0]                         mem_wr_addr, mem_rd_addr;
   logic [DATA_WIDTH-1:0]                 mem_wr_data, mem_rd_data;

   logic                                  mod_start, mod_done;
   logic [CW-1:0]                         mod_rem;
   logic [AW-1:0]                         pos;

   logic                                  req_fire, out_free, is_full, is_empty;
   logic                                  pos_last, cur_more;
   logic [AW-1:0]                         head_dec;

   // Logical position to store address, wrapping at CAPACITY
   function automatic logic [AW-1:0] phys(input logic [AW-1:0] h, input logic [AW-1:0] l);
      logic [AW:0] s;
      s = {1'b0, h} + {1'b0, l};
      if (s >= (AW+1)'(CAPACITY)) begin
         s = s - (AW+1)'(CAPACITY);
      end
      return s[AW-1:0];
   endfunction

   // Common terms
   assign req_ready = (state_ff == clist_pkg::ST_IDLE);
   assign req_fire  = req_valid && req_ready;
   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign is_full   = (count_ff == CW'(CAPACITY));
   assign is_empty  = (count_ff == '0);
   assign pos       = mod_rem[AW-1:0];
   assign pos_last  = ((CW'(pos) + CW'(1)) == count_ff);
   assign cur_more  = ((CW'(cur_ff) + CW'(1)) < count_ff);
   assign head_dec  = (head_ff == '0) ? AW'(CAPACITY - 1) : head_ff - AW'(1);

   // Next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         clist_pkg::ST_IDLE: begin
            if (req_fire) begin
               if ((req_kind == clist_pkg::KIND_READ || req_kind == clist_pkg::KIND_REMOVE)
                   && !is_empty) begin
                  state_in = clist_pkg::ST_DIV;
               end else begin
                  state_in = clist_pkg::ST_RESP;
               end
            end
         end
         clist_pkg::ST_DIV: begin
            if (mod_done) begin
               if (kind_ff == clist_pkg::KIND_READ) begin
                  state_in = clist_pkg::ST_RDWAIT;
               end else if (pos_last) begin
                  state_in = clist_pkg::ST_RESP;
               end else begin
                  state_in = clist_pkg::ST_SHIFT;
               end
            end
         end
         clist_pkg::ST_RDWAIT: state_in = clist_pkg::ST_RESP;
         clist_pkg::ST_SHIFT: begin
            if (!cur_more) begin
               state_in = clist_pkg::ST_RESP;
            end
         end
         clist_pkg::ST_RESP: begin
            if (out_free) begin
               state_in = clist_pkg::ST_IDLE;
            end
         end
         default: state_in = clist_pkg::ST_IDLE;
      endcase
   end

   // Datapath control
   always_comb begin
      head_in       = head_ff;
      count_in      = count_ff;
      cur_in        = cur_ff;
      kind_in       = kind_ff;
      res_value_in  = res_value_ff;
      res_status_in = res_status_ff;
      mem_wr_en     = 1'b0;
      mem_wr_addr   = head_dec;
      mem_wr_data   = DATA_WIDTH'(req_value);
      mem_rd_en     = 1'b0;
      mem_rd_addr   = phys(head_ff, pos);
      mod_start     = 1'b0;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      case (state_ff)
         clist_pkg::ST_IDLE: begin
            if (req_fire) begin
               kind_in       = req_kind;
               res_value_in  = '0;
               res_status_in = clist_pkg::STATUS_OK;
               case (req_kind)
                  clist_pkg::KIND_INSERT: begin
                     if (is_full) begin
                        res_status_in = clist_pkg::STATUS_FULL;
                     end else begin
                        mem_wr_en = 1'b1;
                        head_in   = head_dec;
                        count_in  = count_ff + CW'(1);
                     end
                  end
                  clist_pkg::KIND_READ,
                  clist_pkg::KIND_REMOVE: begin
                     if (is_empty) begin
                        res_status_in = clist_pkg::STATUS_EMPTY;
                     end else begin
                        mod_start = 1'b1;
                     end
                  end
                  default: ;
               endcase
            end
         end
         clist_pkg::ST_DIV: begin
            if (mod_done) begin
               if (kind_ff == clist_pkg::KIND_READ) begin
                  mem_rd_en = 1'b1;
               end else if (pos_last) begin
                  count_in = count_ff - CW'(1);
               end else begin
                  // first entry after the gap
                  mem_rd_en   = 1'b1;
                  mem_rd_addr = phys(head_ff, pos + AW'(1));
                  cur_in      = pos + AW'(1);
               end
            end
         end
         clist_pkg::ST_RDWAIT: begin
            res_value_in = clist_pkg::VALUE_WIDTH'(mem_rd_data);
         end
         clist_pkg::ST_SHIFT: begin
            // move entry cur one place forward, fetch the next
            mem_wr_en   = 1'b1;
            mem_wr_addr = phys(head_ff, cur_ff - AW'(1));
            mem_wr_data = mem_rd_data;
            mem_rd_addr = phys(head_ff, cur_ff + AW'(1));
            if (cur_more) begin
               mem_rd_en = 1'b1;
               cur_in    = cur_ff + AW'(1);
            end else begin
               count_in = count_ff - CW'(1);
            end
         end
         clist_pkg::ST_RESP: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
            end
         end
         default: ;
      endcase
   end

   // Registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= clist_pkg::ST_IDLE;
         head_ff      <= '0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         head_ff      <= head_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      cur_ff        <= cur_in;
      kind_ff       <= kind_in;
      res_value_ff  <= res_value_in;
      res_status_ff <= res_status_in;
      if (state_ff == clist_pkg::ST_RESP && out_free) begin
         rsp_value_ff  <= res_value_ff;
         rsp_length_ff <= clist_pkg::LEN_WIDTH'(count_ff);
         rsp_status_ff <= res_status_ff;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_read_value = rsp_value_ff;
   assign rsp_length     = rsp_length_ff;
   assign rsp_status     = rsp_status_ff;

   // Units
   clist_mod #(
      .CW (CW)
   ) u_mod (
      .clock    (clock),
      .reset    (reset),
      .start    (mod_start),
      .dividend (req_index),
      .divisor  (count_ff),
      .done     (mod_done),
      .rem      (mod_rem)
   );

   clist_mem #(
      .DEPTH (CAPACITY),
      .WIDTH (DATA_WIDTH),
      .AW    (AW)
   ) u_mem (
      .clock   (clock),
      .wr_en   (mem_wr_en),
      .wr_addr (mem_wr_addr),
      .wr_data (mem_wr_data),
      .rd_en   (mem_rd_en),
      .rd_addr (mem_rd_addr),
      .rd_data (mem_rd_data)
   );

   // Checks
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(CAPACITY))
      else $error("length above capacity");

   a_count_step: assert property (@(posedge clock) disable iff (reset)
      (state_ff != clist_pkg::ST_IDLE && state_ff != clist_pkg::ST_DIV
       && state_ff != clist_pkg::ST_SHIFT) |=> $stable(count_ff))
      else $error("length changed outside an update state");

   a_done_in_div: assert property (@(posedge clock) disable iff (reset)
      mod_done |-> (state_ff == clist_pkg::ST_DIV))
      else $error("remainder finished outside the divide state");

   a_rsp_from_resp: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == clist_pkg::ST_RESP))
      else $error("response raised outside the response state");

endmodule
